@@ hdl/bfca_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfca_pkg
// Shared types and codes of the best-fit coalescing allocator.
// ---------------------------------------------------------------------------
package bfca_pkg;

   localparam int ADDR_W  = 48;
   localparam int LEN_W   = 41;
   localparam int BYTES_W = 42;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_IGNORED = 3'd2;
   localparam logic [2:0] ST_BAD     = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic REG_ARENA_BASE = 1'b0;
   localparam logic REG_ARENA_SIZE = 1'b1;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef struct packed {
      logic [1:0]        operation;
      logic [LEN_W-1:0]  byte_count;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] granted_address;
      logic [LEN_W-1:0]  free_total;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef enum logic [2:0] {
      WR_SHIFT_DN, WR_SHIFT_UP, WR_SPLIT, WR_MERGE_BOTH,
      WR_MERGE_PREV, WR_MERGE_NEXT, WR_INSERT, WR_INIT
   } wr_sel_type;

   typedef enum logic [1:0] {
      SUM_KEEP, SUM_SUB, SUM_ADD, SUM_INIT
   } sum_op_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic       eval_alloc;
      logic       eval_free;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       rsp_load;
      logic [2:0] status;
      logic       grant;
      sum_op_type sum_op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       addr_zero;
      logic       range_bad;
      logic       best_found;
      logic       best_exact;
      logic       scan_found;
      logic       free_bad;
      logic       mprev;
      logic       mnext;
      logic       init_zero;
   } stat_type;

endpackage

@@ hdl/best_fit_coalescing_allocator.sv @@
`timescale 1ns / 1ps
// Each request is loaded, decoded and dispatched; initialize and requests rejected before
// any table access go straight to the response. Allocate scans every table entry, then
// shifts the entries above an exact fit down; free scans up to the first entry at or above
// the address, then merges or shifts entries up to insert the new block.
// One transaction is in flight at a time; a new one is accepted
// while a response waits. Reset (synchronous): table empty, free total zero, arena base 0
// and size 16. Table memory contents are not cleared; only entries below the fill count are read.
// ---------------------------------------------------------------------------
// best_fit_coalescing_allocator
// Best-fit free-block allocator with coalescing over one arena.
// ---------------------------------------------------------------------------
module best_fit_coalescing_allocator import bfca_pkg::*; #(
   parameter int MAX_FREE_BLOCKS = 64,
   parameter int MIN_BLOCK_BYTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_data
);

   localparam int IW = $clog2(MAX_FREE_BLOCKS);

   cmd_type       cmd;
   stat_type      stat;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] best_idx;
   logic [IW-1:0] found_idx;

   bfca_ctrl #(
      .MAX_FREE_BLOCKS(MAX_FREE_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .stat      (stat),
      .best_idx  (best_idx),
      .found_idx (found_idx)
   );

   bfca_datapath #(
      .MAX_FREE_BLOCKS(MAX_FREE_BLOCKS),
      .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .stat      (stat),
      .best_idx  (best_idx),
      .found_idx (found_idx)
   );

endmodule

@@ hdl/bfca_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfca_datapath
// Free-block table memory, request registers, scan and merge arithmetic.
// ---------------------------------------------------------------------------
module bfca_datapath import bfca_pkg::*; #(
   parameter int MAX_FREE_BLOCKS = 64,
   parameter int MIN_BLOCK_BYTES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  req_type                            req_data,
   output rsp_type                            rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [ADDR_W-1:0]                  csr_data,
   input  cmd_type                            cmd,
   input  logic [$clog2(MAX_FREE_BLOCKS)-1:0] rd_addr,
   input  logic [$clog2(MAX_FREE_BLOCKS)-1:0] wr_addr,
   output stat_type                           stat,
   output logic [$clog2(MAX_FREE_BLOCKS)-1:0] best_idx,
   output logic [$clog2(MAX_FREE_BLOCKS)-1:0] found_idx
);

   localparam int IW = $clog2(MAX_FREE_BLOCKS);
   localparam logic [BYTES_W-1:0] MIN_BYTES = BYTES_W'(MIN_BLOCK_BYTES);

   entry_type         mem [MAX_FREE_BLOCKS];
   req_type           req_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [ADDR_W-1:0] arena_base_ff;
   logic [LEN_W-1:0]  arena_size_ff;
   logic [LEN_W-1:0]  sum_ff;
   entry_type         rdata_ff;
   logic [IW-1:0]     raddr_ff;
   logic              best_found_ff;
   logic [IW-1:0]     best_idx_ff;
   entry_type         best_ff;
   logic              found_ff;
   logic [IW-1:0]     found_idx_ff;
   entry_type         next_ff;
   logic              has_prev_ff;
   entry_type         prev_ff;
   rsp_type           rsp_ff;

   logic [BYTES_W-1:0] round_v;
   logic [BYTES_W-1:0] round_m;
   logic [LEN_W-1:0]   b41;
   logic [ADDR_W:0]    end_addr;
   logic [ADDR_W:0]    prev_end;
   logic [LEN_W:0]     prev_plus;
   logic [LEN_W:0]     next_plus;
   logic [LEN_W+1:0]   both_sum;
   logic               mprev0;
   logic               mnext0;
   logic [ADDR_W:0]    init_avail;
   logic [LEN_W-1:0]   init_len;
   logic [LEN_W-1:0]   sum_next;
   logic [LEN_W+1:0]   sum_add;
   logic [IW-1:0]      waddr;
   entry_type          wdata;

   assign csr_ready = 1'b1;
   assign rsp_data  = rsp_ff;
   assign best_idx  = best_idx_ff;
   assign found_idx = found_idx_ff;

   // Round up to a power of two by smearing the bits below the top one.
   always_comb begin
      round_v = ({1'b0, req_ff.byte_count} < MIN_BYTES) ? MIN_BYTES
                                                        : {1'b0, req_ff.byte_count};
      round_m = round_v - BYTES_W'(1);
      round_m = round_m | (round_m >> 1);
      round_m = round_m | (round_m >> 2);
      round_m = round_m | (round_m >> 4);
      round_m = round_m | (round_m >> 8);
      round_m = round_m | (round_m >> 16);
      round_m = round_m | (round_m >> 32);
   end

   always_comb begin
      b41       = bytes_ff[LEN_W-1:0];
      end_addr  = {1'b0, req_ff.block_address} + (ADDR_W+1)'(b41);
      prev_end  = {1'b0, prev_ff.start} + (ADDR_W+1)'(prev_ff.length);
      prev_plus = {1'b0, prev_ff.length} + {1'b0, b41};
      next_plus = {1'b0, next_ff.length} + {1'b0, b41};
      both_sum  = {1'b0, prev_plus} + (LEN_W+2)'(next_ff.length);
      mprev0    = has_prev_ff && (prev_end == {1'b0, req_ff.block_address})
                  && !prev_plus[LEN_W];
      mnext0    = found_ff && (end_addr == {1'b0, next_ff.start}) && !next_plus[LEN_W];
      init_avail = {1'b1, {ADDR_W{1'b0}}} - {1'b0, arena_base_ff};
      init_len  = ((ADDR_W+1)'(arena_size_ff) > init_avail) ? init_avail[LEN_W-1:0]
                                                             : arena_size_ff;
   end

   always_comb begin
      stat.op         = req_ff.operation;
      stat.count_zero = (req_ff.byte_count == '0);
      stat.addr_zero  = (req_ff.block_address == '0);
      stat.range_bad  = bytes_ff[LEN_W] || (end_addr[ADDR_W] && (end_addr[ADDR_W-1:0] != '0));
      stat.best_found = best_found_ff;
      stat.best_exact = ({1'b0, best_ff.length} == bytes_ff);
      stat.scan_found = found_ff;
      stat.free_bad   = (found_ff && (next_ff.start == req_ff.block_address))
                        || (has_prev_ff && (prev_end > {1'b0, req_ff.block_address}))
                        || (found_ff && (end_addr > {1'b0, next_ff.start}));
      stat.mprev      = mprev0;
      stat.mnext      = mnext0 && !(mprev0 && (both_sum > (LEN_W+2)'(LEN_MAX)));
      stat.init_zero  = (init_len == '0);
   end

   always_comb begin
      waddr = wr_addr;
      wdata = rdata_ff;
      unique case (cmd.wr_sel)
         WR_SHIFT_DN: waddr = raddr_ff - IW'(1);
         WR_SHIFT_UP: waddr = raddr_ff + IW'(1);
         WR_SPLIT: begin
            wdata.start  = best_ff.start + ADDR_W'(b41);
            wdata.length = best_ff.length - b41;
         end
         WR_MERGE_BOTH: begin
            wdata.start  = prev_ff.start;
            wdata.length = both_sum[LEN_W-1:0];
         end
         WR_MERGE_PREV: begin
            wdata.start  = prev_ff.start;
            wdata.length = prev_plus[LEN_W-1:0];
         end
         WR_MERGE_NEXT: begin
            wdata.start  = req_ff.block_address;
            wdata.length = next_plus[LEN_W-1:0];
         end
         WR_INSERT: begin
            wdata.start  = req_ff.block_address;
            wdata.length = b41;
         end
         WR_INIT: begin
            wdata.start  = arena_base_ff;
            wdata.length = init_len;
         end
         default: wdata = rdata_ff;
      endcase
   end

   always_comb begin
      sum_add  = (LEN_W+2)'(sum_ff) + (LEN_W+2)'(bytes_ff);
      sum_next = sum_ff;
      unique case (cmd.sum_op)
         SUM_KEEP: sum_next = sum_ff;
         SUM_SUB:  sum_next = ({1'b0, sum_ff} > bytes_ff) ? (sum_ff - b41) : '0;
         SUM_ADD:  sum_next = (sum_add > (LEN_W+2)'(LEN_MAX)) ? LEN_MAX
                                                             : sum_add[LEN_W-1:0];
         SUM_INIT: sum_next = init_len;
         default:  sum_next = sum_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
         raddr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_base_ff <= '0;
         arena_size_ff <= LEN_W'(16);
         sum_ff        <= '0;
         best_found_ff <= 1'b0;
         found_ff      <= 1'b0;
         has_prev_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == REG_ARENA_BASE) begin
               arena_base_ff <= csr_data;
            end else begin
               arena_size_ff <= csr_data[LEN_W-1:0];
            end
         end
         if (cmd.load) begin
            best_found_ff <= 1'b0;
            found_ff      <= 1'b0;
            has_prev_ff   <= 1'b0;
         end
         if (cmd.eval_alloc && ({1'b0, rdata_ff.length} >= bytes_ff)
             && (!best_found_ff || (rdata_ff.length < best_ff.length))) begin
            best_found_ff <= 1'b1;
         end
         if (cmd.eval_free && !found_ff) begin
            if (rdata_ff.start >= req_ff.block_address) begin
               found_ff <= 1'b1;
            end else begin
               has_prev_ff <= 1'b1;
            end
         end
         if (cmd.rsp_load) begin
            sum_ff <= sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= round_m + BYTES_W'(1);
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.eval_alloc && ({1'b0, rdata_ff.length} >= bytes_ff)
          && (!best_found_ff || (rdata_ff.length < best_ff.length))) begin
         best_idx_ff <= raddr_ff;
         best_ff     <= rdata_ff;
      end
      if (cmd.eval_free && !found_ff) begin
         if (rdata_ff.start >= req_ff.block_address) begin
            found_idx_ff <= raddr_ff;
            next_ff      <= rdata_ff;
         end else begin
            prev_ff <= rdata_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.status          <= cmd.status;
         rsp_ff.granted_address <= cmd.grant ? best_ff.start : '0;
         rsp_ff.free_total      <= sum_next;
      end
   end

endmodule

@@ hdl/bfca_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfca_ctrl
// Sequencer for table scans, entry shifts and response handshake.
// ---------------------------------------------------------------------------
module bfca_ctrl import bfca_pkg::*; #(
   parameter int MAX_FREE_BLOCKS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cmd_type                            cmd,
   output logic [$clog2(MAX_FREE_BLOCKS)-1:0] rd_addr,
   output logic [$clog2(MAX_FREE_BLOCKS)-1:0] wr_addr,
   input  stat_type                           stat,
   input  logic [$clog2(MAX_FREE_BLOCKS)-1:0] best_idx,
   input  logic [$clog2(MAX_FREE_BLOCKS)-1:0] found_idx
);

   localparam int IW = $clog2(MAX_FREE_BLOCKS);
   localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_DISP, S_A_SCAN, S_A_DEC, S_F_SCAN, S_F_DEC,
      S_SHIFT_DN, S_SHIFT_UP, S_INSERT, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      ENT_KEEP, ENT_INC, ENT_DEC, ENT_SET0, ENT_SET1
   } ent_op_type;

   state_type  state_ff, state_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] entries_ff, entries_in;
   logic [2:0] status_ff, status_in;
   ent_op_type ent_op_ff, ent_op_in;
   sum_op_type sum_op_ff, sum_op_in;
   logic       grant_ff, grant_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rvalid_ff;
   logic [CW-1:0] pos_now;
   logic [CW-1:0] pos_less;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      pos_in       = pos_ff;
      entries_in   = entries_ff;
      status_in    = status_ff;
      ent_op_in    = ent_op_ff;
      sum_op_in    = sum_op_ff;
      grant_in     = grant_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      rd_addr      = '0;
      wr_addr      = '0;
      pos_now      = stat.scan_found ? CW'(found_idx) : entries_ff;
      pos_less     = pos_now - CW'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: state_in = S_DISP;
         S_DISP: begin
            iss_in    = '0;
            grant_in  = 1'b0;
            sum_op_in = SUM_KEEP;
            ent_op_in = ENT_KEEP;
            state_in  = S_DONE;
            unique case (stat.op)
               OP_ALLOC: begin
                  if (stat.count_zero) begin
                     status_in = ST_IGNORED;
                  end else begin
                     state_in = S_A_SCAN;
                  end
               end
               OP_FREE: begin
                  if (stat.count_zero || stat.addr_zero) begin
                     status_in = ST_IGNORED;
                  end else if (stat.range_bad) begin
                     status_in = ST_BAD;
                  end else begin
                     state_in = S_F_SCAN;
                  end
               end
               OP_INIT: begin
                  cmd.wr_en  = !stat.init_zero;
                  cmd.wr_sel = WR_INIT;
                  status_in  = ST_OK;
                  sum_op_in  = SUM_INIT;
                  ent_op_in  = stat.init_zero ? ENT_SET0 : ENT_SET1;
               end
               default: status_in = ST_IGNORED;
            endcase
         end
         S_A_SCAN: begin
            if (iss_ff < entries_ff) begin
               cmd.rd_en = 1'b1;
               rd_addr   = iss_ff[IW-1:0];
               iss_in    = iss_ff + CW'(1);
            end
            cmd.eval_alloc = rvalid_ff;
            if ((iss_ff == entries_ff) && !rvalid_ff) begin
               state_in = S_A_DEC;
            end
         end
         S_A_DEC: begin
            if (!stat.best_found) begin
               status_in = ST_NOFIT;
               state_in  = S_DONE;
            end else begin
               status_in = ST_OK;
               grant_in  = 1'b1;
               sum_op_in = SUM_SUB;
               if (stat.best_exact) begin
                  // The exact fit leaves the table; close the gap behind it.
                  ent_op_in = ENT_DEC;
                  iss_in    = CW'(best_idx) + CW'(1);
                  state_in  = S_SHIFT_DN;
               end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WR_SPLIT;
                  wr_addr    = best_idx;
                  state_in   = S_DONE;
               end
            end
         end
         S_F_SCAN: begin
            if ((iss_ff < entries_ff) && !stat.scan_found) begin
               cmd.rd_en = 1'b1;
               rd_addr   = iss_ff[IW-1:0];
               iss_in    = iss_ff + CW'(1);
            end
            cmd.eval_free = rvalid_ff;
            if ((stat.scan_found || (iss_ff == entries_ff)) && !rvalid_ff) begin
               state_in = S_F_DEC;
            end
         end
         S_F_DEC: begin
            state_in  = S_DONE;
            status_in = ST_OK;
            sum_op_in = SUM_ADD;
            if (stat.free_bad) begin
               status_in = ST_BAD;
               sum_op_in = SUM_KEEP;
            end else if (stat.mprev && stat.mnext) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_MERGE_BOTH;
               wr_addr    = pos_less[IW-1:0];
               ent_op_in  = ENT_DEC;
               iss_in     = pos_now + CW'(1);
               state_in   = S_SHIFT_DN;
            end else if (stat.mprev) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_MERGE_PREV;
               wr_addr    = pos_less[IW-1:0];
            end else if (stat.mnext) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_MERGE_NEXT;
               wr_addr    = pos_now[IW-1:0];
            end else if (entries_ff >= CW'(MAX_FREE_BLOCKS)) begin
               status_in = ST_FULL;
               sum_op_in = SUM_KEEP;
            end else begin
               ent_op_in = ENT_INC;
               iss_in    = entries_ff;
               pos_in    = pos_now;
               state_in  = S_SHIFT_UP;
            end
         end
         S_SHIFT_DN: begin
            if (iss_ff < entries_ff) begin
               cmd.rd_en = 1'b1;
               rd_addr   = iss_ff[IW-1:0];
               iss_in    = iss_ff + CW'(1);
            end
            if (rvalid_ff) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SHIFT_DN;
            end
            if ((iss_ff == entries_ff) && !rvalid_ff) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT_UP: begin
            // Walk down from the top so no entry is overwritten before it moves.
            if (iss_ff > pos_ff) begin
               cmd.rd_en = 1'b1;
               rd_addr   = IW'(iss_ff - CW'(1));
               iss_in    = iss_ff - CW'(1);
            end
            if (rvalid_ff) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SHIFT_UP;
            end
            if ((iss_ff == pos_ff) && !rvalid_ff) begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_INSERT;
            wr_addr    = pos_ff[IW-1:0];
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.status   = status_ff;
               cmd.grant    = grant_ff;
               cmd.sum_op   = sum_op_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               unique case (ent_op_ff)
                  ENT_KEEP: entries_in = entries_ff;
                  ENT_INC:  entries_in = entries_ff + CW'(1);
                  ENT_DEC:  entries_in = entries_ff - CW'(1);
                  ENT_SET0: entries_in = '0;
                  ENT_SET1: entries_in = CW'(1);
                  default:  entries_in = entries_ff;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_ff       <= '0;
         pos_ff       <= '0;
         entries_ff   <= '0;
         status_ff    <= ST_OK;
         ent_op_ff    <= ENT_KEEP;
         sum_op_ff    <= SUM_KEEP;
         grant_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         pos_ff       <= pos_in;
         entries_ff   <= entries_in;
         status_ff    <= status_in;
         ent_op_ff    <= ent_op_in;
         sum_op_ff    <= sum_op_in;
         grant_ff     <= grant_in;
         rsp_valid_ff <= rsp_valid_in;
         rvalid_ff    <= cmd.rd_en;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");

   a_entries_bound: assert property (@(posedge clock) disable iff (reset)
      entries_ff <= CW'(MAX_FREE_BLOCKS))
      else $error("table count beyond capacity");

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_PREP))
      else $error("accepted transaction not started");

   a_load_done: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("response load did not raise valid");

endmodule

@@ test/best_fit_coalescing_allocator_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// best_fit_coalescing_allocator_tb
// Drives allocate, free and initialize requests through several arena
// settings. A scoreboard predicts the free table, the granted address and
// the free total for each request and compares every response with it.
// ---------------------------------------------------------------------------
module best_fit_coalescing_allocator_tb import bfca_pkg::*; ;

   localparam logic [1:0]  OP_UNUSED  = 2'd3;
   localparam logic [63:0] SIZE_MASK  = 64'h1FF_FFFF_FFFF;
   localparam logic [63:0] ADDR_TOP   = 64'h1_0000_0000_0000;
   localparam int          TABLE_SLOTS = 64;
   localparam int          MIN_GRAIN   = 16;

   class alloc_scoreboard;
      logic [63:0] arena_lo;
      logic [63:0] arena_bytes;
      logic [63:0] hole_start [TABLE_SLOTS];
      logic [63:0] hole_len [TABLE_SLOTS];
      int          hole_count;
      logic [63:0] bytes_free;
      rsp_type     awaited [$];
      int          errors;

      function new();
         arena_lo    = 0;
         arena_bytes = 16;
         hole_count  = 0;
         bytes_free  = 0;
         errors      = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void write_reg(logic idx, logic [ADDR_W-1:0] value);
         if (idx == REG_ARENA_BASE) begin
            arena_lo = {16'd0, value};
         end else begin
            arena_bytes = {16'd0, value} & SIZE_MASK;
         end
      endfunction

      function logic [63:0] round_up(logic [63:0] n);
         logic [63:0] v;
         logic [63:0] p;
         v = (n < MIN_GRAIN) ? MIN_GRAIN : n;
         p = 1;
         while (p < v) p = p << 1;
         return p;
      endfunction

      function logic [2:0] allocate(logic [63:0] count, output logic [63:0] granted);
         logic [63:0] bytes;
         int best;
         granted = 0;
         if (count == 0) return ST_IGNORED;
         bytes = round_up(count);
         best = -1;
         for (int i = 0; i < hole_count; i++) begin
            if (hole_len[i] >= bytes && (best < 0 || hole_len[i] < hole_len[best])) best = i;
         end
         if (best < 0) return ST_NOFIT;
         granted = hole_start[best];
         if (hole_len[best] == bytes) begin
            for (int i = best; i < hole_count - 1; i++) begin
               hole_start[i] = hole_start[i+1];
               hole_len[i]   = hole_len[i+1];
            end
            hole_count--;
         end else begin
            hole_start[best] += bytes;
            hole_len[best]   -= bytes;
         end
         bytes_free = (bytes_free > bytes) ? bytes_free - bytes : 0;
         return ST_OK;
      endfunction

      function logic [2:0] release_block(logic [63:0] count, logic [63:0] addr);
         logic [63:0] bytes;
         logic [63:0] stop;
         logic [63:0] prev_end;
         int pos;
         bit join_prev;
         bit join_next;
         join_prev = 0;
         join_next = 0;
         pos = 0;
         if (count == 0 || addr == 0) return ST_IGNORED;
         bytes = round_up(count);
         if (bytes > SIZE_MASK) return ST_BAD;
         stop = addr + bytes;
         if (stop > ADDR_TOP) return ST_BAD;
         while (pos < hole_count && hole_start[pos] < addr) pos++;
         if (pos < hole_count && hole_start[pos] == addr) return ST_BAD;
         if (pos > 0) begin
            prev_end = hole_start[pos-1] + hole_len[pos-1];
            if (prev_end > addr) return ST_BAD;
            join_prev = (prev_end == addr) && (hole_len[pos-1] + bytes <= SIZE_MASK);
         end
         if (pos < hole_count) begin
            if (stop > hole_start[pos]) return ST_BAD;
            join_next = (stop == hole_start[pos]) && (bytes + hole_len[pos] <= SIZE_MASK);
         end
         // The combined block must still fit the length field; the join with the previous block goes first.
         if (join_prev && join_next && hole_len[pos-1] + bytes + hole_len[pos] > SIZE_MASK)
            join_next = 0;
         if (join_prev && join_next) begin
            hole_len[pos-1] += bytes + hole_len[pos];
            for (int i = pos; i < hole_count - 1; i++) begin
               hole_start[i] = hole_start[i+1];
               hole_len[i]   = hole_len[i+1];
            end
            hole_count--;
         end else if (join_prev) begin
            hole_len[pos-1] += bytes;
         end else if (join_next) begin
            hole_start[pos] = addr;
            hole_len[pos]  += bytes;
         end else begin
            if (hole_count >= TABLE_SLOTS) return ST_FULL;
            for (int i = hole_count; i > pos; i--) begin
               hole_start[i] = hole_start[i-1];
               hole_len[i]   = hole_len[i-1];
            end
            hole_start[pos] = addr;
            hole_len[pos]   = bytes;
            hole_count++;
         end
         bytes_free += bytes;
         if (bytes_free > SIZE_MASK) bytes_free = SIZE_MASK;
         return ST_OK;
      endfunction

      function void initialize();
         logic [63:0] span;
         span = arena_bytes;
         if (span > ADDR_TOP - arena_lo) span = ADDR_TOP - arena_lo;
         if (span == 0) begin
            hole_count = 0;
         end else begin
            hole_start[0] = arena_lo;
            hole_len[0]   = span;
            hole_count    = 1;
         end
         bytes_free = span;
      endfunction

      function rsp_type note_request(req_type r);
         rsp_type e;
         logic [63:0] granted;
         granted = 0;
         case (r.operation)
            OP_ALLOC: e.status = allocate({23'd0, r.byte_count}, granted);
            OP_FREE:  e.status = release_block({23'd0, r.byte_count}, {16'd0, r.block_address});
            OP_INIT: begin
               initialize();
               e.status = ST_OK;
            end
            default:  e.status = ST_IGNORED;
         endcase
         e.granted_address = (e.status == ST_OK) ? granted[ADDR_W-1:0] : '0;
         e.free_total      = bytes_free[LEN_W-1:0];
         awaited.insert(awaited.size(), e);
         return e;
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected response %p", got));
         end else begin
            e = awaited.pop_front();
            if (got.status !== e.status)
               report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.granted_address !== e.granted_address)
               report($sformatf("granted_address %h, expected %h",
                                got.granted_address, e.granted_address));
            if (got.free_total !== e.free_total)
               report($sformatf("free_total %h, expected %h", got.free_total, e.free_total));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_index;
   logic [ADDR_W-1:0] csr_data;

   alloc_scoreboard   sb;
   bit                tx_quiet;
   bit                rx_quiet;
   logic [ADDR_W-1:0] live_addr [$];
   logic [LEN_W-1:0]  live_count [$];
   logic [ADDR_W-1:0] last_freed_addr;
   logic [LEN_W-1:0]  last_freed_count;

   best_fit_coalescing_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function int stall_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 120);
   endfunction

   function int send_gap();
      int r;
      if (tx_quiet) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   // A valid that stays high for the next transaction is never lowered in between.
   task send_request(input req_type r, output rsp_type e);
      int gap;
      gap = send_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      e = sb.note_request(r);
   endtask

   task issue(input logic [1:0] op, input logic [LEN_W-1:0] count,
              input logic [ADDR_W-1:0] addr, output rsp_type e);
      req_type r;
      r.operation     = op;
      r.byte_count    = count;
      r.block_address = addr;
      send_request(r, e);
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_csr(input logic idx, input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task do_alloc(input logic [LEN_W-1:0] count);
      rsp_type e;
      issue(OP_ALLOC, count, ADDR_W'({$urandom, $urandom}), e);
      if (e.status == ST_OK) begin
         live_addr.insert(live_addr.size(), e.granted_address);
         live_count.insert(live_count.size(), count);
      end
   endtask

   task free_live(input int idx);
      rsp_type e;
      last_freed_addr  = live_addr[idx];
      last_freed_count = live_count[idx];
      live_addr.delete(idx);
      live_count.delete(idx);
      issue(OP_FREE, last_freed_count, last_freed_addr, e);
   endtask

   task do_init();
      rsp_type e;
      issue(OP_INIT, LEN_W'({$urandom, $urandom}), ADDR_W'({$urandom, $urandom}), e);
      live_addr.delete();
      live_count.delete();
   endtask

   // Many small grants followed by freeing every other one fragments the table.
   task fragment_burst(input int n);
      int first;
      first = live_addr.size();
      repeat (n) do_alloc(LEN_W'($urandom_range(1, 16)));
      for (int i = live_addr.size() - 1; i >= first; i -= 2) free_live(i);
   endtask

   task run_random(input int n, input int max_req);
      rsp_type e;
      int k;
      logic [63:0] raw;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) == 0) tx_quiet = ~tx_quiet;
         k = $urandom_range(99);
         if (k < 40) begin
            if ($urandom_range(99) < 60) do_alloc(LEN_W'($urandom_range(1, 64)));
            else do_alloc(LEN_W'($urandom_range(1, max_req)));
         end else if (k < 75) begin
            if (live_addr.size() > 0) free_live($urandom_range(0, live_addr.size() - 1));
            else do_alloc(LEN_W'($urandom_range(1, 64)));
         end else if (k < 83) begin
            // Double free of the last released block, or a free into a random spot.
            if ($urandom_range(1)) issue(OP_FREE, last_freed_count, last_freed_addr, e);
            else issue(OP_FREE, LEN_W'($urandom_range(1, 128)),
                       sb.arena_lo[ADDR_W-1:0]
                       + ADDR_W'($urandom_range(0, 4095) & ~32'hF), e);
         end else if (k < 92) begin
            raw = {$urandom, $urandom};
            issue(2'($urandom_range(0, 3)), raw[LEN_W-1:0] >> $urandom_range(0, 40),
                  ADDR_W'({$urandom, $urandom}), e);
         end else if (k < 95) begin
            fragment_burst($urandom_range(4, 12));
         end else if (k < 97) begin
            do_init();
         end else begin
            issue(OP_UNUSED, LEN_W'({$urandom, $urandom}), ADDR_W'({$urandom, $urandom}), e);
         end
      end
   endtask

   // Response side: random stalls with quiet stretches.
   initial begin
      int stall;
      stall     = 0;
      rsp_ready = 1'b0;
      rx_quiet  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ($urandom_range(999) == 0) rx_quiet = ~rx_quiet;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rx_quiet && $urandom_range(99) < 25) stall = stall_length();
         end
      end
   end

   initial begin
      #50_000_000;
      $display("best_fit_coalescing_allocator_tb NOT OK");
      $finish;
   end

   initial begin
      rsp_type e;
      logic [ADDR_W-1:0] top_base;
      sb        = new();
      tx_quiet  = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = REG_ARENA_BASE;
      csr_data  = '0;
      last_freed_addr  = 48'h10;
      last_freed_count = 41'd16;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset arena: a single 16-byte block at address zero.
      issue(OP_ALLOC, 41'd4, 48'd0, e);
      do_init();
      do_alloc(41'd1);
      issue(OP_FREE, 41'd16, 48'd0, e);
      do_alloc(41'd17);
      issue(OP_UNUSED, 41'd0, 48'd0, e);

      // Directed: huge arena near the length limit.
      wait_idle();
      write_csr(REG_ARENA_BASE, 48'h1000);
      write_csr(REG_ARENA_SIZE, 48'h100_0000_0000);
      do_init();
      issue(OP_ALLOC, 41'd0, 48'd0, e);
      do_alloc(41'd1);
      issue(OP_ALLOC, 41'h100_0000_0000, 48'd0, e);
      issue(OP_FREE, 41'd5, 48'd0, e);
      issue(OP_FREE, 41'd0, 48'h2000, e);
      issue(OP_FREE, 41'd16, 48'h1010, e);
      issue(OP_FREE, 41'd32, 48'h1008, e);
      issue(OP_FREE, 41'h100_0000_0001, 48'h8000_0000_0000, e);
      issue(OP_FREE, 41'h1FF_FFFF_FFFF, 48'h8000_0000_0000, e);
      issue(OP_FREE, 41'd32, 48'hFFFF_FFFF_FFF0, e);
      issue(OP_FREE, 41'd16, 48'hFFFF_FFFF_FFF0, e);
      issue(OP_FREE, 41'h100_0000_0000, 48'h100_0000_1000, e);
      free_live(0);
      do_alloc(41'h0FF_FFFF_FFFF);
      issue(OP_UNUSED, 41'h1FF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, e);
      run_random(90, 1 << 30);

      // Small arena where the table fills up.
      wait_idle();
      write_csr(REG_ARENA_BASE, 48'h4000);
      write_csr(REG_ARENA_SIZE, 48'd4096);
      do_init();
      fragment_burst(200);
      run_random(210, 300);

      wait_idle();
      write_csr(REG_ARENA_BASE, 48'd0);
      write_csr(REG_ARENA_SIZE, 48'd2048);
      do_init();
      run_random(150, 200);

      // Arena at the top of the address space, cut down to what fits.
      wait_idle();
      top_base = 48'hFFFF_FFFF_F800;
      write_csr(REG_ARENA_BASE, top_base);
      write_csr(REG_ARENA_SIZE, 48'h100_0000_0000);
      do_init();
      run_random(120, 256);

      wait_idle();
      write_csr(REG_ARENA_BASE, 48'hFFFF_FFFF_FFFF);
      do_init();
      run_random(25, 64);

      // Size register written with only bits above the field set is taken as zero.
      wait_idle();
      write_csr(REG_ARENA_BASE, ADDR_W'({$urandom, $urandom}));
      write_csr(REG_ARENA_SIZE, 48'hFE00_0000_0000);
      do_init();
      run_random(25, 64);

      wait_idle();
      write_csr(REG_ARENA_SIZE, 48'd16);
      write_csr(REG_ARENA_BASE, 48'h10);
      do_init();
      run_random(40, 32);

      wait_idle();
      write_csr(REG_ARENA_BASE, {16'd0, $urandom} & ~48'hFFF);
      write_csr(REG_ARENA_SIZE, 48'd8192);
      do_init();
      fragment_burst(150);
      run_random(270, 600);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("best_fit_coalescing_allocator_tb OK");
      end else begin
         $display("best_fit_coalescing_allocator_tb NOT OK");
      end
      $finish;
   end

endmodule
